// ===== hdl/afr_pkg.sv =====
// Shared types, constants and codes for the aspect-fit rectangle block.
// Used by afr_front, afr_queue, afr_back and aspect_fit_rectangle_top.
// No dependencies.
package afr_pkg;

    // Fixed-point format of every coordinate and side
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;

    localparam int PROD_W   = 2 * COORD_BITS;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;

    // Stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = 6 * COORD_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * COORD_BITS + STATUS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Divider: restoring, a fixed number of quotient bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = PROD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Sizing modes
    localparam logic [MODE_W-1:0] MODE_FIT       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIT_WIDTH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FILL      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STRETCH   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COPY      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    // Job kinds decided by the front
    localparam logic [OP_W-1:0] OP_ZERO  = 3'd0; // a zero side: empty rectangle
    localparam logic [OP_W-1:0] OP_NONE  = 3'd1; // unused mode: empty rectangle
    localparam logic [OP_W-1:0] OP_PASS  = 3'd2; // target size as is
    localparam logic [OP_W-1:0] OP_DIV_W = 3'd3; // height = target, width divided
    localparam logic [OP_W-1:0] OP_DIV_H = 3'd4; // width = target, height divided
    localparam logic [OP_W-1:0] OP_COPY  = 3'd5; // native size, centred on pixels

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic signed [COORD_BITS-1:0] scoord_t;

    typedef struct packed {
        coord_t  th;
        coord_t  tw;
        scoord_t ty;
        scoord_t tx;
        coord_t  sh;
        coord_t  sw;
    } item_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PROD_W-1:0] num;
        coord_t            den;
        item_t             item;
    } job_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        coord_t              h;
        coord_t              w;
        scoord_t             y;
        scoord_t             x;
    } result_t;

endpackage

// ===== hdl/afr_front.sv =====
// Front end: takes input transfers, forms the two cross products and
// classifies each item into a job for the back end. Uses afr_pkg.
module afr_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  afr_pkg::item_t             in_item,
    input  logic [afr_pkg::MODE_W-1:0] mode,
    output logic                       job_valid,
    input  logic                       job_ready,
    output afr_pkg::job_t              job
);

    logic                       stage_valid_reg;
    afr_pkg::item_t             item_reg;
    logic [afr_pkg::PROD_W-1:0] lhs_reg;
    logic [afr_pkg::PROD_W-1:0] rhs_reg;
    logic [afr_pkg::PROD_W-1:0] lhs_next;
    logic [afr_pkg::PROD_W-1:0] rhs_next;
    logic                       take;
    logic                       any_zero;

    assign in_ready  = !stage_valid_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = stage_valid_reg;

    // tw*sh and sw*th, registered before the compare
    assign lhs_next = in_item.tw * in_item.sh;
    assign rhs_next = in_item.sw * in_item.th;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
            lhs_reg  <= lhs_next;
            rhs_reg  <= rhs_next;
        end
    end

    assign any_zero = (item_reg.sw == '0) || (item_reg.sh == '0) ||
                      (item_reg.tw == '0) || (item_reg.th == '0);

    always_comb
    begin
        job      = '0;
        job.item = item_reg;
        job.op   = afr_pkg::OP_NONE;
        job.num  = lhs_reg;
        job.den  = item_reg.sw;
        if (any_zero)
        begin
            job.op = afr_pkg::OP_ZERO;
        end
        else
        begin
            unique case (mode)
                afr_pkg::MODE_FIT,
                afr_pkg::MODE_FILL:
                begin
                    // fit shrinks the wider side, fill grows the narrower one
                    priority if (lhs_reg == rhs_reg)
                    begin
                        job.op = afr_pkg::OP_PASS;
                    end
                    else if ((lhs_reg > rhs_reg) == (mode == afr_pkg::MODE_FIT))
                    begin
                        job.op  = afr_pkg::OP_DIV_W;
                        job.num = rhs_reg;
                        job.den = item_reg.sh;
                    end
                    else
                    begin
                        job.op = afr_pkg::OP_DIV_H;
                    end
                end
                afr_pkg::MODE_FIT_WIDTH: job.op = afr_pkg::OP_DIV_H;
                afr_pkg::MODE_STRETCH:   job.op = afr_pkg::OP_PASS;
                afr_pkg::MODE_COPY:      job.op = afr_pkg::OP_COPY;
                default:                 job.op = afr_pkg::OP_NONE;
            endcase
        end
    end

endmodule

// ===== hdl/afr_queue.sv =====
// Short job queue between front and back end, so either side can stall.
// Register slots with wrapping pointers. Uses afr_pkg.
module afr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  afr_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output afr_pkg::job_t pop_job
);

    afr_pkg::job_t               slots [afr_pkg::QUEUE_DEPTH];
    logic [afr_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [afr_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [afr_pkg::QCNT_W-1:0] count_reg;
    logic                       push;
    logic                       pop;

    assign push_ready = (count_reg != afr_pkg::QCNT_W'(afr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slots[rd_ptr_reg];

    function automatic logic [afr_pkg::QPTR_W-1:0] bump(input logic [afr_pkg::QPTR_W-1:0] p);
        logic [afr_pkg::QPTR_W-1:0] n;
        if (p == afr_pkg::QPTR_W'(afr_pkg::QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/afr_back.sv =====
// Back end: runs one job at a time, division jobs through a radix-4 restoring
// divider; rounds and saturates the sides, places the origin, holds the result.
// Uses afr_pkg.
module afr_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  afr_pkg::job_t    job,
    output logic             out_valid,
    input  logic             out_ready,
    output afr_pkg::result_t result
);

    localparam int CW = afr_pkg::COORD_BITS;
    localparam int PW = afr_pkg::PROD_W;
    localparam int EW = CW + 3;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SIZE  = 2'd2;
    localparam logic [1:0] ST_PLACE = 2'd3;

    localparam logic [CW:0]   ROUND_HALF = (CW + 1)'((1 << afr_pkg::FRAC_BITS) >> 1);
    localparam logic [CW-1:0] FRAC_MASK  = CW'((1 << afr_pkg::FRAC_BITS) - 1);
    localparam logic [EW-1:0] PIX_HALF   = EW'(1 << afr_pkg::FRAC_BITS);
    localparam logic signed [EW-1:0] SMAX_E = $signed({4'b0000, {(CW - 1){1'b1}}});
    localparam logic signed [EW-1:0] SMIN_E = $signed({4'b1111, {(CW - 1){1'b0}}});

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [afr_pkg::DIV_CNT_W-1:0] cnt_reg;
    afr_pkg::job_t                 cur_reg;
    logic [PW-1:0]                 quo_reg;
    logic [PW-1:0]                 quo_next;
    logic [CW-1:0]                 rem_reg;
    logic [CW-1:0]                 rem_next;
    afr_pkg::coord_t               w_reg;
    afr_pkg::coord_t               h_reg;
    logic                          sat_reg;
    afr_pkg::coord_t               w_next;
    afr_pkg::coord_t               h_next;
    logic                          sat_next;
    logic                          out_valid_reg;
    afr_pkg::result_t              result_reg;
    afr_pkg::result_t              result_next;
    logic                          load;
    logic                          place;
    logic                          is_div;

    // division step signals
    logic [CW:0]                   shr;
    logic                          qbit;

    // rounding of the quotient and of the copy sizes
    logic                          round_up;
    logic [CW:0]                   qsum;
    logic                          qsat;
    afr_pkg::coord_t               qval;
    logic [CW:0]                   csw;
    logic [CW:0]                   csh;

    // origin placement
    logic signed [EW-1:0]          x_full;
    logic signed [EW-1:0]          y_full;
    logic [CW:0]                   x_clamp;
    logic [CW:0]                   y_clamp;

    function automatic logic signed [EW-1:0] place_coord(
        input logic [afr_pkg::OP_W-1:0] op,
        input logic signed [CW-1:0]     t,
        input logic [CW-1:0]            ts,
        input logic [CW-1:0]            s
    );
        logic signed [CW+1:0] diff;
        logic signed [CW+1:0] v;
        logic signed [CW+1:0] hd;
        logic [CW+1:0]        mag;
        logic [EW-1:0]        ksum;
        logic [EW-1:0]        r;
        logic signed [EW-1:0] res;
        diff = $signed({2'b00, ts}) - $signed({2'b00, s});
        if (op == afr_pkg::OP_COPY)
        begin
            // 2t + ts - s has one extra fraction bit; round to pixels, ties away
            v    = $signed({t[CW-1], t, 1'b0}) + diff;
            mag  = v[CW+1] ? $unsigned(~v + 1'b1) : $unsigned(v);
            ksum = {1'b0, mag} + PIX_HALF;
            r    = (ksum >> (afr_pkg::FRAC_BITS + 1)) << afr_pkg::FRAC_BITS;
            res  = v[CW+1] ? -$signed(r) : $signed(r);
        end
        else
        begin
            hd  = diff >>> 1;
            res = $signed({{3{t[CW-1]}}, t}) + $signed({hd[CW+1], hd});
        end
        return res;
    endfunction

    function automatic logic [CW:0] clamp_coord(input logic signed [EW-1:0] v);
        logic [CW:0] res;
        if (v > SMAX_E)
        begin
            res = {1'b1, SMAX_E[CW-1:0]};
        end
        else if (v < SMIN_E)
        begin
            res = {1'b1, SMIN_E[CW-1:0]};
        end
        else
        begin
            res = {1'b0, v[CW-1:0]};
        end
        return res;
    endfunction

    assign job_ready = (state_reg == ST_IDLE);
    assign load      = job_valid && job_ready;
    assign place     = (state_reg == ST_PLACE) && (!out_valid_reg || out_ready);
    assign is_div    = (job.op == afr_pkg::OP_DIV_W) || (job.op == afr_pkg::OP_DIV_H);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // two restoring steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        shr      = '0;
        qbit     = 1'b0;
        for (int i = 0; i < afr_pkg::DIV_BITS_PER_CYCLE; i++)
        begin
            shr  = {rem_next, quo_next[PW-1]};
            qbit = (shr >= {1'b0, cur_reg.den});
            if (qbit)
            begin
                rem_next = CW'(shr - {1'b0, cur_reg.den});
            end
            else
            begin
                rem_next = shr[CW-1:0];
            end
            quo_next = {quo_next[PW-2:0], qbit};
        end
    end

    // side lengths, rounded and saturated
    always_comb
    begin
        round_up = ({rem_reg, 1'b0} >= {1'b0, cur_reg.den});
        qsum     = {1'b0, quo_reg[CW-1:0]} + (CW + 1)'(round_up);
        qsat     = (|quo_reg[PW-1:CW]) || qsum[CW];
        qval     = qsat ? '1 : qsum[CW-1:0];
        csw      = {1'b0, cur_reg.item.sw} + ROUND_HALF;
        csh      = {1'b0, cur_reg.item.sh} + ROUND_HALF;
        w_next   = '0;
        h_next   = '0;
        sat_next = 1'b0;
        unique case (cur_reg.op)
            afr_pkg::OP_PASS:
            begin
                w_next = cur_reg.item.tw;
                h_next = cur_reg.item.th;
            end
            afr_pkg::OP_DIV_W:
            begin
                w_next   = qval;
                h_next   = cur_reg.item.th;
                sat_next = qsat;
            end
            afr_pkg::OP_DIV_H:
            begin
                w_next   = cur_reg.item.tw;
                h_next   = qval;
                sat_next = qsat;
            end
            afr_pkg::OP_COPY:
            begin
                w_next   = csw[CW] ? '1 : (csw[CW-1:0] & ~FRAC_MASK);
                h_next   = csh[CW] ? '1 : (csh[CW-1:0] & ~FRAC_MASK);
                sat_next = csw[CW] || csh[CW];
            end
            default:
            begin
                w_next = '0;
                h_next = '0;
            end
        endcase
    end

    // origins and status
    always_comb
    begin
        x_full  = place_coord(cur_reg.op, cur_reg.item.tx, cur_reg.item.tw, w_reg);
        y_full  = place_coord(cur_reg.op, cur_reg.item.ty, cur_reg.item.th, h_reg);
        x_clamp = clamp_coord(x_full);
        y_clamp = clamp_coord(y_full);
        result_next = '0;
        unique case (cur_reg.op)
            afr_pkg::OP_ZERO:
            begin
                result_next.status = afr_pkg::STATUS_ZERO;
            end
            afr_pkg::OP_NONE:
            begin
                result_next.status = afr_pkg::STATUS_OK;
            end
            default:
            begin
                result_next.x = x_clamp[CW-1:0];
                result_next.y = y_clamp[CW-1:0];
                result_next.w = w_reg;
                result_next.h = h_reg;
                result_next.status = (sat_reg || x_clamp[CW] || y_clamp[CW]) ?
                                     afr_pkg::STATUS_SAT : afr_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = is_div ? ST_DIV : ST_SIZE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                if (place)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (place)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                cnt_reg <= afr_pkg::DIV_CNT_W'(afr_pkg::DIV_CYCLES - 1);
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= job;
            quo_reg <= job.num;
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (state_reg == ST_SIZE)
        begin
            w_reg   <= w_next;
            h_reg   <= h_next;
            sat_reg <= sat_next;
        end
        if (place)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== hdl/aspect_fit_rectangle_top.sv =====
// Top level of the aspect-fit rectangle block: config register, stream
// unpacking and packing, front end, job queue, back end.
// Depends on afr_pkg, afr_front, afr_queue, afr_back.
//
// Channel   Direction  Transfer when            Contents
// s_axis    in         tvalid & tready          source size, target rectangle
// m_axis    out        tvalid & tready          placed rectangle, status
// cfg       in         cfg_wr_en                sizing_mode
//
// Division items (fit and fill with unequal aspects, fit width): the back end
// takes the job, divides at two quotient bits a divider cycle over the 48-bit
// product, rounds the sides and places the origin; others skip the divide.
// The divider sets the sustained rate; the front takes a transfer every cycle
// while the 4-entry queue has room. A held result stalls the back end.
// Reset clears the valid flags, the queue and sizing_mode (fit).
module aspect_fit_rectangle_top
(
    input  logic                           clk,
    input  logic                           rst_n,

    // fields from bit 0 up: source_width, source_height, target_x,
    // target_y, target_width, target_height
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [afr_pkg::IN_DATA_W-1:0]  s_axis_tdata,

    // fields from bit 0 up: out_x, out_y, out_width, out_height, status,
    // then zero fill
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [afr_pkg::OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                           cfg_wr_en,
    input  logic [afr_pkg::MODE_W-1:0]     cfg_wr_data
);

    localparam int CW = afr_pkg::COORD_BITS;

    logic [afr_pkg::MODE_W-1:0] sizing_mode_reg;
    afr_pkg::item_t             in_item;
    logic                       front_valid;
    logic                       front_ready;
    afr_pkg::job_t              front_job;
    logic                       back_valid;
    logic                       back_ready;
    afr_pkg::job_t              back_job;
    afr_pkg::result_t           res;

    // Hold the sizing mode; the user must write it only while the block is idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizing_mode_reg <= afr_pkg::MODE_FIT;
        end
        else if (cfg_wr_en)
        begin
            sizing_mode_reg <= cfg_wr_data;
        end
    end

    // Unpack the input transfer
    assign in_item.sw = s_axis_tdata[CW-1:0];
    assign in_item.sh = s_axis_tdata[2*CW-1:CW];
    assign in_item.tx = $signed(s_axis_tdata[3*CW-1:2*CW]);
    assign in_item.ty = $signed(s_axis_tdata[4*CW-1:3*CW]);
    assign in_item.tw = s_axis_tdata[5*CW-1:4*CW];
    assign in_item.th = s_axis_tdata[6*CW-1:5*CW];

    // Front: multiply and classify
    afr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .mode      (sizing_mode_reg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // Queue: decouple the front from the slow divider
    afr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    // Back: divide, round, saturate, place; holds the result register
    afr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (res)
    );

    // Pack the result transfer, zero fill to whole bytes
    assign m_axis_tdata = afr_pkg::OUT_DATA_W'({res.status, res.h, res.w, res.y, res.x});

    // Status is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.status == afr_pkg::STATUS_OK ||
                           res.status == afr_pkg::STATUS_ZERO ||
                           res.status == afr_pkg::STATUS_SAT))
        else $error("undefined status on result");

    // A zero-side result carries an empty rectangle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.status == afr_pkg::STATUS_ZERO) |->
            (res.x == '0 && res.y == '0 && res.w == '0 && res.h == '0))
        else $error("zero-side result with nonzero rectangle");

endmodule
